// File: sv/mst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MTU signature table package
// Shared widths, codes, defaults and the item type passed from front to back.
// ----------------------------------------------------------------------------
package mst_pkg;

    localparam int BUCKETS_DEF = 64;
    localparam int ENTRIES_DEF = 8;
    localparam int QUEUE_DEPTH = 4;

    localparam int MTU_W     = 16;
    localparam int VALUE_W   = 17;
    localparam int LABEL_W   = 8;
    localparam int HDR_W     = 8;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [HDR_W-1:0] HDR_V4_RESET = 8'd40;
    localparam logic [HDR_W-1:0] HDR_V6_RESET = 8'd60;

    localparam logic [CFG_IDX_W-1:0] CFG_HDR_V4 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_V6 = 1'b1;

    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_LOOKUP   = 1'b1;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_STORED  = 3'd0;
    localparam status_t STATUS_MATCHED = 3'd1;
    localparam status_t STATUS_NOMATCH = 3'd2;
    localparam status_t STATUS_SKIPPED = 3'd3;
    localparam status_t STATUS_BADVAL  = 3'd4;
    localparam status_t STATUS_FULL    = 3'd5;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_STORE  = 2'd0;
    localparam kind_t KIND_BAD    = 2'd1;
    localparam kind_t KIND_LOOKUP = 2'd2;
    localparam kind_t KIND_SKIP   = 2'd3;

    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        logic [LABEL_W-1:0] label;
        logic               side;
    } item_t;

endpackage

// File: sv/mst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/mst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MTU signature table front end
// Takes an item, classifies it, forms the MTU and its bucket, and queues it.
// ----------------------------------------------------------------------------
module mst_front #(
    parameter int BUCKETS = mst_pkg::BUCKETS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   accept,
    input  logic                                   operation,
    input  logic [mst_pkg::MTU_W-1:0]              mtu_value,
    input  logic [mst_pkg::LABEL_W-1:0]            label_id,
    input  logic [mst_pkg::MTU_W-1:0]              mss,
    input  logic                                   is_ipv6,
    input  logic                                   syn_already_sent,
    input  logic                                   to_server,
    input  logic [mst_pkg::HDR_W-1:0]              hdr_v4,
    input  logic [mst_pkg::HDR_W-1:0]              hdr_v6,
    input  logic                                   queue_full,
    output logic                                   active,
    output logic                                   push,
    output mst_pkg::item_t                         push_item,
    output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] push_bucket
);

    localparam int BKT_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int VW        = mst_pkg::VALUE_W;
    // Reciprocal for value mod BUCKETS: the quotient estimate is exact or one low.
    localparam int MOD_SHIFT = VW + $clog2(BUCKETS) + 1;
    localparam int RECIP_W   = MOD_SHIFT + 1;
    localparam longint unsigned RECIP_L = (64'd1 << MOD_SHIFT) / BUCKETS;
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_L);
    localparam logic [VW-1:0]      BUCKETS_V = VW'(BUCKETS);

    localparam logic [1:0] STEP_MUL  = 2'd0;
    localparam logic [1:0] STEP_QB   = 2'd1;
    localparam logic [1:0] STEP_PUSH = 2'd2;

    logic                   active_reg;
    logic [1:0]             step_reg;
    mst_pkg::item_t         item_reg;
    logic [VW+RECIP_W-1:0]  prod_reg;
    logic [VW-1:0]          qb_reg;

    mst_pkg::item_t         item_next;
    logic [VW-1:0]          quot;
    logic [2*VW-1:0]        qb_full;
    logic [VW-1:0]          rem_raw;
    logic [VW-1:0]          rem_fix;

    always_comb
    begin
        item_next = '0;
        if (operation == mst_pkg::OP_REGISTER)
        begin
            item_next.kind  = (mtu_value == '0) ? mst_pkg::KIND_BAD : mst_pkg::KIND_STORE;
            item_next.value = VW'(mtu_value);
            item_next.label = label_id;
            item_next.side  = 1'b0;
        end
        else
        begin
            item_next.kind  = ((mss == '0) || syn_already_sent) ? mst_pkg::KIND_SKIP
                                                                : mst_pkg::KIND_LOOKUP;
            item_next.value = VW'(mss) + VW'(is_ipv6 ? hdr_v6 : hdr_v4);
            item_next.label = '0;
            item_next.side  = to_server;
        end
    end

    assign quot    = prod_reg[MOD_SHIFT +: VW];
    assign qb_full = {{VW{1'b0}}, quot} * {{VW{1'b0}}, BUCKETS_V};
    assign rem_raw = item_reg.value - qb_reg;
    assign rem_fix = (rem_raw >= BUCKETS_V) ? (rem_raw - BUCKETS_V) : rem_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= STEP_MUL;
        end
        else if (accept)
        begin
            active_reg <= 1'b1;
            step_reg   <= STEP_MUL;
        end
        else if (active_reg)
        begin
            unique case (step_reg)
                STEP_MUL:  step_reg <= STEP_QB;
                STEP_QB:   step_reg <= STEP_PUSH;
                STEP_PUSH:
                begin
                    if (!queue_full)
                    begin
                        active_reg <= 1'b0;
                    end
                end
                default:   step_reg <= STEP_MUL;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
        prod_reg <= {{RECIP_W{1'b0}}, item_reg.value} * {{VW{1'b0}}, RECIP};
        qb_reg   <= qb_full[VW-1:0];
    end

    assign active      = active_reg;
    assign push        = active_reg && (step_reg == STEP_PUSH) && !queue_full;
    assign push_item   = item_reg;
    assign push_bucket = rem_fix[BKT_W-1:0];

endmodule

// File: sv/mst_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MTU signature table item queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module mst_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mst_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == FULL_COUNT);
    assign empty = (count_reg == '0);

endmodule

// File: sv/mst_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MTU signature table back end
// Owns the bucket fill counts and entry store; stores, scans and reports.
// ----------------------------------------------------------------------------
module mst_back #(
    parameter int BUCKETS            = mst_pkg::BUCKETS_DEF,
    parameter int ENTRIES_PER_BUCKET = mst_pkg::ENTRIES_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_empty,
    input  mst_pkg::item_t                         q_item,
    input  logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] q_bucket,
    output logic                                   pop,
    output logic                                   clearing,
    output logic                                   done,
    output mst_pkg::status_t                       status,
    output logic [mst_pkg::LABEL_W-1:0]            label_out,
    output logic [mst_pkg::VALUE_W-1:0]            mtu_out,
    output logic                                   side_is_server
);

    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int TOTAL   = BUCKETS * ENTRIES_PER_BUCKET;
    localparam int ADDR_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int FILL_W  = $clog2(ENTRIES_PER_BUCKET + 1);
    localparam int SUM_W   = ADDR_W + FILL_W;
    localparam int ENTRY_W = mst_pkg::LABEL_W + mst_pkg::MTU_W;
    localparam int VW      = mst_pkg::VALUE_W;

    localparam logic [FILL_W-1:0] EPB_F     = FILL_W'(ENTRIES_PER_BUCKET);
    localparam logic [ADDR_W-1:0] EPB_A     = ADDR_W'(ENTRIES_PER_BUCKET);
    localparam logic [BKT_W-1:0]  LAST_BKT  = BKT_W'(BUCKETS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FILL = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]                   state_reg,  state_next;
    mst_pkg::item_t               item_reg,   item_next;
    logic [BKT_W-1:0]             bucket_reg, bucket_next;
    logic [ADDR_W-1:0]            base_reg,   base_next;
    logic [FILL_W-1:0]            slot_reg,   slot_next;
    logic [FILL_W-1:0]            limit_reg,  limit_next;
    logic                         clear_reg;
    logic [BKT_W-1:0]             clr_idx_reg;
    logic                         done_reg,   done_next;
    mst_pkg::status_t             status_reg, status_next;
    logic [mst_pkg::LABEL_W-1:0]  label_reg,  label_next;
    logic [VW-1:0]                mtu_reg,    mtu_next;
    logic                         side_reg,   side_next;

    logic                         fill_we;
    logic [BKT_W-1:0]             fill_waddr;
    logic [FILL_W-1:0]            fill_wdata;
    logic [BKT_W-1:0]             fill_raddr;
    logic [FILL_W-1:0]            fill_rdata;
    logic [FILL_W-1:0]            fill_lim;
    logic                         entry_we;
    logic [ADDR_W-1:0]            entry_addr_wr;
    logic [ADDR_W-1:0]            entry_raddr;
    logic [ENTRY_W-1:0]           entry_rdata;
    logic [mst_pkg::MTU_W-1:0]    entry_mtu;
    logic [mst_pkg::LABEL_W-1:0]  entry_label;
    logic [2*ADDR_W-1:0]          base_prod;
    logic [SUM_W-1:0]             addr_fill;
    logic [SUM_W-1:0]             addr_scan;
    logic [FILL_W-1:0]            slot_inc;

    mst_ram #(
        .WIDTH (FILL_W),
        .DEPTH (BUCKETS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .raddr (fill_raddr),
        .rdata (fill_rdata)
    );

    mst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TOTAL)
    ) u_entry_ram (
        .clk   (clk),
        .we    (entry_we),
        .waddr (entry_addr_wr),
        .wdata ({item_reg.label, item_reg.value[mst_pkg::MTU_W-1:0]}),
        .raddr (entry_raddr),
        .rdata (entry_rdata)
    );

    assign entry_mtu   = entry_rdata[mst_pkg::MTU_W-1:0];
    assign entry_label = entry_rdata[ENTRY_W-1:mst_pkg::MTU_W];
    assign base_prod   = {{ADDR_W{1'b0}}, ADDR_W'(q_bucket)} * {{ADDR_W{1'b0}}, EPB_A};
    assign fill_lim    = (fill_rdata > EPB_F) ? EPB_F : fill_rdata;
    assign slot_inc    = slot_reg + 1'b1;
    assign addr_fill   = SUM_W'(base_reg) + SUM_W'(fill_rdata);
    assign addr_scan   = SUM_W'(base_reg) + SUM_W'(slot_inc);
    assign entry_addr_wr = addr_fill[ADDR_W-1:0];
    assign fill_raddr  = q_bucket;

    // The fill store is swept to zero after reset; the back end waits for it.
    always_comb
    begin
        fill_we    = 1'b0;
        fill_waddr = bucket_reg;
        fill_wdata = fill_rdata + 1'b1;
        entry_we   = 1'b0;
        entry_raddr = base_reg;
        pop        = 1'b0;

        state_next  = state_reg;
        item_next   = item_reg;
        bucket_next = bucket_reg;
        base_next   = base_reg;
        slot_next   = slot_reg;
        limit_next  = limit_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        label_next  = '0;
        mtu_next    = '0;
        side_next   = 1'b0;

        if (clear_reg)
        begin
            fill_we    = 1'b1;
            fill_waddr = clr_idx_reg;
            fill_wdata = '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        pop         = 1'b1;
                        item_next   = q_item;
                        bucket_next = q_bucket;
                        base_next   = base_prod[ADDR_W-1:0];
                        if (q_item.kind == mst_pkg::KIND_BAD)
                        begin
                            done_next   = 1'b1;
                            status_next = mst_pkg::STATUS_BADVAL;
                        end
                        else if (q_item.kind == mst_pkg::KIND_SKIP)
                        begin
                            done_next   = 1'b1;
                            status_next = mst_pkg::STATUS_SKIPPED;
                            side_next   = q_item.side;
                        end
                        else
                        begin
                            state_next = ST_FILL;
                        end
                    end
                end
                ST_FILL:
                begin
                    if (item_reg.kind == mst_pkg::KIND_STORE)
                    begin
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                        if (fill_rdata >= EPB_F)
                        begin
                            status_next = mst_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            fill_we     = 1'b1;
                            entry_we    = 1'b1;
                            status_next = mst_pkg::STATUS_STORED;
                        end
                    end
                    else if (fill_lim == '0)
                    begin
                        state_next  = ST_IDLE;
                        done_next   = 1'b1;
                        status_next = mst_pkg::STATUS_NOMATCH;
                        mtu_next    = item_reg.value;
                        side_next   = item_reg.side;
                    end
                    else
                    begin
                        entry_raddr = base_reg;
                        slot_next   = '0;
                        limit_next  = fill_lim;
                        state_next  = ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    entry_raddr = addr_scan[ADDR_W-1:0];
                    slot_next   = slot_inc;
                    if ({1'b0, entry_mtu} == item_reg.value)
                    begin
                        state_next  = ST_IDLE;
                        done_next   = 1'b1;
                        status_next = mst_pkg::STATUS_MATCHED;
                        label_next  = entry_label;
                        mtu_next    = item_reg.value;
                        side_next   = item_reg.side;
                    end
                    else if (slot_inc == limit_reg)
                    begin
                        state_next  = ST_IDLE;
                        done_next   = 1'b1;
                        status_next = mst_pkg::STATUS_NOMATCH;
                        mtu_next    = item_reg.value;
                        side_next   = item_reg.side;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            clear_reg   <= 1'b1;
            clr_idx_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (clear_reg)
            begin
                if (clr_idx_reg == LAST_BKT)
                begin
                    clear_reg <= 1'b0;
                end
                else
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        bucket_reg <= bucket_next;
        base_reg   <= base_next;
        slot_reg   <= slot_next;
        limit_reg  <= limit_next;
        status_reg <= status_next;
        label_reg  <= label_next;
        mtu_reg    <= mtu_next;
        side_reg   <= side_next;
    end

    assign clearing       = clear_reg;
    assign done           = done_reg;
    assign status         = status_reg;
    assign label_out      = label_reg;
    assign mtu_out        = mtu_reg;
    assign side_is_server = side_reg;

endmodule

// File: sv/mtu_signature_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MTU signature table
// Hashed table from MTU values to link-type labels, with packet lookups.
// ----------------------------------------------------------------------------
// The front end forms each bucket by reciprocal multiply and takes no new item
// until the last one has been pushed into the queue; a full queue holds that push.
// The back end scans a bucket one entry per cycle through the entry RAM read port.
// After reset, busy stays high while the fill counts are cleared.
// Results are strobed by done for one cycle; the receiver cannot stall them.
module mtu_signature_table #(
    parameter int BUCKETS            = mst_pkg::BUCKETS_DEF,
    parameter int ENTRIES_PER_BUCKET = mst_pkg::ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              operation,
    input  logic [mst_pkg::MTU_W-1:0]         mtu_value,
    input  logic [mst_pkg::LABEL_W-1:0]       label_id,
    input  logic [mst_pkg::MTU_W-1:0]         mss,
    input  logic                              is_ipv6,
    input  logic                              syn_already_sent,
    input  logic                              to_server,
    input  logic                              cfg_we,
    input  logic [mst_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mst_pkg::HDR_W-1:0]         cfg_data,
    output logic                              done,
    output logic [mst_pkg::STATUS_W-1:0]      status,
    output logic [mst_pkg::LABEL_W-1:0]       label_out,
    output logic [mst_pkg::VALUE_W-1:0]       mtu_out,
    output logic                              side_is_server
);

    localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int Q_W   = $bits(mst_pkg::item_t) + BKT_W;

    logic [mst_pkg::HDR_W-1:0] hdr_v4_reg;
    logic [mst_pkg::HDR_W-1:0] hdr_v6_reg;

    logic                 accept;
    logic                 front_active;
    logic                 push;
    mst_pkg::item_t       push_item;
    logic [BKT_W-1:0]     push_bucket;
    logic [Q_W-1:0]       q_head;
    logic                 q_full;
    logic                 q_empty;
    logic                 pop;
    logic                 clearing;
    mst_pkg::item_t       q_item;
    logic [BKT_W-1:0]     q_bucket;
    mst_pkg::status_t     status_int;

    assign accept = start && !busy;
    assign busy   = front_active || clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_v4_reg <= mst_pkg::HDR_V4_RESET;
            hdr_v6_reg <= mst_pkg::HDR_V6_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mst_pkg::CFG_HDR_V4: hdr_v4_reg <= cfg_data;
                mst_pkg::CFG_HDR_V6: hdr_v6_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    mst_front #(
        .BUCKETS (BUCKETS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .operation        (operation),
        .mtu_value        (mtu_value),
        .label_id         (label_id),
        .mss              (mss),
        .is_ipv6          (is_ipv6),
        .syn_already_sent (syn_already_sent),
        .to_server        (to_server),
        .hdr_v4           (hdr_v4_reg),
        .hdr_v6           (hdr_v6_reg),
        .queue_full       (q_full),
        .active           (front_active),
        .push             (push),
        .push_item        (push_item),
        .push_bucket      (push_bucket)
    );

    mst_queue #(
        .WIDTH (Q_W),
        .DEPTH (mst_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_item, push_bucket}),
        .pop       (pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign q_item   = q_head[Q_W-1:BKT_W];
    assign q_bucket = q_head[BKT_W-1:0];

    mst_back #(
        .BUCKETS            (BUCKETS),
        .ENTRIES_PER_BUCKET (ENTRIES_PER_BUCKET)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_item         (q_item),
        .q_bucket       (q_bucket),
        .pop            (pop),
        .clearing       (clearing),
        .done           (done),
        .status         (status_int),
        .label_out      (label_out),
        .mtu_out        (mtu_out),
        .side_is_server (side_is_server)
    );

    assign status = status_int;

endmodule

// File: sv/mst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MTU signature table checker
// Port-level properties of the table, attached to the top level by bind.
// ----------------------------------------------------------------------------
module mst_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              operation,
    input logic [mst_pkg::MTU_W-1:0]         mtu_value,
    input logic [mst_pkg::LABEL_W-1:0]       label_id,
    input logic [mst_pkg::MTU_W-1:0]         mss,
    input logic                              is_ipv6,
    input logic                              syn_already_sent,
    input logic                              to_server,
    input logic                              cfg_we,
    input logic [mst_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [mst_pkg::HDR_W-1:0]         cfg_data,
    input logic                              done,
    input logic [mst_pkg::STATUS_W-1:0]      status,
    input logic [mst_pkg::LABEL_W-1:0]       label_out,
    input logic [mst_pkg::VALUE_W-1:0]       mtu_out,
    input logic                              side_is_server
);

    // An accepted item keeps the front end occupied for the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after an accepted item");

    a_register_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == mst_pkg::STATUS_STORED || status == mst_pkg::STATUS_BADVAL ||
                  status == mst_pkg::STATUS_FULL))
        |-> (label_out == '0 && mtu_out == '0 && !side_is_server))
        else $error("register item result carries lookup data");

    a_skip_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == mst_pkg::STATUS_SKIPPED) |-> (label_out == '0 && mtu_out == '0))
        else $error("skipped lookup carries a label or MTU");

    // A stored value is 16 bits wide, so a match can never report a wider MTU.
    a_match_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == mst_pkg::STATUS_MATCHED) |-> (!mtu_out[16] && mtu_out != '0))
        else $error("matched MTU outside the stored range");

endmodule

bind mtu_signature_table mst_checker u_mst_checker (.*);

// File: sim/mtu_signature_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MTU signature table testbench
// Drives register and lookup items through the start/busy handshake. Each
// accepted item is run through a local model of the hashed MTU table, and the
// strobed results are checked field by field against that prediction in order.
// Header sizes are rewritten between batches while the table is idle.
// ----------------------------------------------------------------------------
module mtu_signature_table_tb;

    import mst_pkg::*;

    localparam int NUM_BUCKETS  = BUCKETS_DEF;
    localparam int BUCKET_DEPTH = ENTRIES_DEF;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic               op;
        logic [MTU_W-1:0]   mtu_value;
        logic [LABEL_W-1:0] label;
        logic [MTU_W-1:0]   mss;
        logic               ipv6;
        logic               syn_sent;
        logic               server;
    } sig_item_t;

    typedef struct {
        status_t            status;
        logic [LABEL_W-1:0] label;
        logic [VALUE_W-1:0] mtu;
        logic               side;
    } sig_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 operation = OP_REGISTER;
    logic [MTU_W-1:0]     mtu_value = '0;
    logic [LABEL_W-1:0]   label_id = '0;
    logic [MTU_W-1:0]     mss = '0;
    logic                 is_ipv6 = 1'b0;
    logic                 syn_already_sent = 1'b0;
    logic                 to_server = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_HDR_V4;
    logic [HDR_W-1:0]     cfg_data = '0;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [LABEL_W-1:0]   label_out;
    logic [VALUE_W-1:0]   mtu_out;
    logic                 side_is_server;

    // Local copy of the table and the header sizes.
    logic [MTU_W-1:0]   table_mtu   [NUM_BUCKETS][BUCKET_DEPTH];
    logic [LABEL_W-1:0] table_label [NUM_BUCKETS][BUCKET_DEPTH];
    int                 bucket_used [NUM_BUCKETS];
    logic [HDR_W-1:0]   hdr_v4 = HDR_V4_RESET;
    logic [HDR_W-1:0]   hdr_v6 = HDR_V6_RESET;

    sig_item_t   pending_items[$];
    sig_result_t expected_results[$];
    logic [MTU_W-1:0] known_mtus[$];
    sig_item_t   drive_item;
    logic        item_taken = 1'b0;
    int          gap_pct = 24;
    int          error_count = 0;
    int          cycle_count = 0;

    mtu_signature_table dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .operation        (operation),
        .mtu_value        (mtu_value),
        .label_id         (label_id),
        .mss              (mss),
        .is_ipv6          (is_ipv6),
        .syn_already_sent (syn_already_sent),
        .to_server        (to_server),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .status           (status),
        .label_out        (label_out),
        .mtu_out          (mtu_out),
        .side_is_server   (side_is_server)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic sig_result_t predict_signature(sig_item_t it);
        sig_result_t        r;
        logic [VALUE_W-1:0] full_mtu;
        int                 b;
        int                 used;
        logic               found;
        r.status = STATUS_STORED;
        r.label  = '0;
        r.mtu    = '0;
        r.side   = 1'b0;
        found    = 1'b0;
        if (it.op == OP_REGISTER)
        begin
            if (it.mtu_value == '0)
            begin
                r.status = STATUS_BADVAL;
            end
            else
            begin
                b = it.mtu_value % NUM_BUCKETS;
                used = bucket_used[b];
                if (used >= BUCKET_DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    table_mtu[b][used]   = it.mtu_value;
                    table_label[b][used] = it.label;
                    bucket_used[b]       = used + 1;
                end
            end
        end
        else
        begin
            r.side = it.server;
            if (it.mss == '0 || it.syn_sent)
            begin
                r.status = STATUS_SKIPPED;
            end
            else
            begin
                full_mtu = VALUE_W'(it.mss) + VALUE_W'(it.ipv6 ? hdr_v6 : hdr_v4);
                r.mtu    = full_mtu;
                r.status = STATUS_NOMATCH;
                b = full_mtu % NUM_BUCKETS;
                // Oldest entry wins when one MTU was registered more than once.
                for (int i = 0; i < bucket_used[b]; i++)
                begin
                    if (!found && VALUE_W'(table_mtu[b][i]) == full_mtu)
                    begin
                        found    = 1'b1;
                        r.status = STATUS_MATCHED;
                        r.label  = table_label[b][i];
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic sig_item_t make_register(logic [MTU_W-1:0] value,
                                                logic [LABEL_W-1:0] lbl);
        sig_item_t it;
        it.op        = OP_REGISTER;
        it.mtu_value = value;
        it.label     = lbl;
        it.mss       = MTU_W'($urandom);
        it.ipv6      = 1'($urandom);
        it.syn_sent  = 1'($urandom);
        it.server    = 1'($urandom);
        return it;
    endfunction

    function automatic sig_item_t make_lookup(logic [MTU_W-1:0] seg, logic v6,
                                              logic syn, logic srv);
        sig_item_t it;
        it.op        = OP_LOOKUP;
        it.mtu_value = MTU_W'($urandom);
        it.label     = LABEL_W'($urandom);
        it.mss       = seg;
        it.ipv6      = v6;
        it.syn_sent  = syn;
        it.server    = srv;
        return it;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Driver: presents the next item at the falling edge once the last one was taken.
    always @(negedge clk)
    begin
        if (rst_n && (!start || item_taken))
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                drive_item = pending_items.pop_front();
                operation        <= drive_item.op;
                mtu_value        <= drive_item.mtu_value;
                label_id         <= drive_item.label;
                mss              <= drive_item.mss;
                is_ipv6          <= drive_item.ipv6;
                syn_already_sent <= drive_item.syn_sent;
                to_server        <= drive_item.server;
                start            <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: records accepted items and checks strobed results.
    always @(posedge clk)
    begin
        sig_result_t want;
        if (!rst_n)
        begin
            item_taken <= 1'b0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with status %0d arrived with nothing expected", status);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("label_out", want.label, label_out);
                    check_field("mtu_out", want.mtu, mtu_out);
                    check_field("side_is_server", want.side, side_is_server);
                end
            end
            item_taken <= start && !busy;
            if (start && !busy)
                expected_results.push_back(predict_signature(drive_item));
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_items.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_header(logic [CFG_IDX_W-1:0] idx, logic [HDR_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_HDR_V4)
            hdr_v4 = val;
        else
            hdr_v6 = val;
    endtask

    task automatic queue_register(logic [MTU_W-1:0] value, logic [LABEL_W-1:0] lbl);
        pending_items.push_back(make_register(value, lbl));
        if (value != '0)
            known_mtus.push_back(value);
    endtask

    // Mostly lookups aimed at registered MTUs, with one bucket pushed to full.
    task automatic queue_random_batch(int count);
        int               focus;
        int               pick;
        logic             v6;
        logic [HDR_W-1:0] hdr;
        logic [MTU_W-1:0] target;
        logic [MTU_W-1:0] seg;
        focus = $urandom_range(NUM_BUCKETS - 1);
        pending_items.push_back(make_lookup(16'hFFFF, 1'b0, 1'b0, 1'($urandom)));
        pending_items.push_back(make_lookup(16'hFFFF, 1'b1, 1'b0, 1'($urandom)));
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                pick = $urandom_range(99);
                if (pick < 35)
                    target = MTU_W'($urandom_range(1023) * NUM_BUCKETS + focus);
                else if (pick < 45)
                    target = '0;
                else if (pick < 60 && known_mtus.size() != 0)
                    target = known_mtus[$urandom_range(known_mtus.size() - 1)];
                else
                    target = MTU_W'($urandom);
                queue_register(target, LABEL_W'($urandom));
            end
            else
            begin
                v6  = 1'($urandom);
                hdr = v6 ? hdr_v6 : hdr_v4;
                pick = $urandom_range(99);
                if (pick < 70 && known_mtus.size() != 0)
                begin
                    target = known_mtus[$urandom_range(known_mtus.size() - 1)];
                    seg = (target > hdr) ? MTU_W'(target - hdr) : target;
                    // Same bucket, different value: the scan cannot stop on the target entry.
                    if ($urandom_range(99) < 20)
                        seg = MTU_W'(seg + NUM_BUCKETS * $urandom_range(1, 8));
                    pending_items.push_back(make_lookup(seg, v6, 1'b0, 1'($urandom)));
                end
                else if (pick < 80)
                begin
                    pending_items.push_back(make_lookup(MTU_W'($urandom), v6, 1'b1,
                                                        1'($urandom)));
                end
                else if (pick < 85)
                begin
                    pending_items.push_back(make_lookup('0, v6, 1'($urandom),
                                                        1'($urandom)));
                end
                else
                begin
                    pending_items.push_back(make_lookup(MTU_W'($urandom), v6,
                                                        1'($urandom), 1'($urandom)));
                end
            end
        end
    endtask

    initial
    begin
        for (int b = 0; b < NUM_BUCKETS; b++)
            bucket_used[b] = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // The block clears its fill counts before it takes anything.
        while (busy)
            @(posedge clk);

        // Directed part, with the header sizes still at their reset values.
        gap_pct = 24;
        queue_register(16'd0, 8'd9);
        queue_register(16'hFFFF, 8'hFF);
        queue_register(16'd1500, 8'd1);
        queue_register(16'd1500, 8'd2);
        for (int k = 1; k <= 6; k++)
            queue_register(MTU_W'(1500 + NUM_BUCKETS * k), LABEL_W'(k + 16));
        queue_register(MTU_W'(1500 + NUM_BUCKETS * 7), 8'd99);
        queue_register(16'd64, 8'd7);
        pending_items.push_back(make_lookup(16'd1460, 1'b0, 1'b0, 1'b1));
        pending_items.push_back(make_lookup(16'd1440, 1'b1, 1'b0, 1'b0));
        pending_items.push_back(make_lookup(16'd0, 1'b0, 1'b0, 1'b1));
        pending_items.push_back(make_lookup(16'd1460, 1'b0, 1'b1, 1'b0));
        pending_items.push_back(make_lookup(16'd65495, 1'b0, 1'b0, 1'b1));
        pending_items.push_back(make_lookup(16'hFFFF, 1'b1, 1'b0, 1'b0));
        pending_items.push_back(make_lookup(16'hFFFF, 1'b0, 1'b0, 1'b1));
        pending_items.push_back(make_lookup(16'd1, 1'b0, 1'b0, 1'b0));
        pending_items.push_back(make_lookup(16'd24, 1'b0, 1'b0, 1'b1));
        pending_items.push_back(make_lookup(MTU_W'(1500 + NUM_BUCKETS * 3 - 60), 1'b1,
                                            1'b0, 1'b1));
        wait_idle();

        write_header(CFG_HDR_V4, 8'd0);
        write_header(CFG_HDR_V6, 8'hFF);
        queue_random_batch(200);
        wait_idle();

        gap_pct = 69;
        write_header(CFG_HDR_V4, 8'hFF);
        write_header(CFG_HDR_V6, 8'd0);
        queue_random_batch(200);
        wait_idle();

        gap_pct = 0;
        write_header(CFG_HDR_V4, HDR_W'($urandom));
        write_header(CFG_HDR_V6, HDR_W'($urandom));
        queue_random_batch(200);
        wait_idle();

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
sv/mst_pkg.sv
sv/mst_ram.sv
sv/mst_front.sv
sv/mst_queue.sv
sv/mst_back.sv
sv/mtu_signature_table.sv
sv/mst_checker.sv
sim/mtu_signature_table_tb.sv
